/* hw/rtl/aarch64_reloc_patch_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the relocation patcher
// Shared concurrent assertion wrappers, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef AARCH64_RELOC_PATCH_DEFINES_SVH
`define AARCH64_RELOC_PATCH_DEFINES_SVH

// Checked outside reset only
`define ARP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included
`define ARP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/arp_pkg.sv */
// ----------------------------------------------------------------------------
// arp_pkg
// Relocation type numbers, status codes and byte swap helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package arp_pkg;

  // ELF relocation type numbers
  localparam logic [11:0] T_ABS64              = 12'd257;
  localparam logic [11:0] T_PREL32             = 12'd261;
  localparam logic [11:0] T_LD_PREL_LO19       = 12'd273;
  localparam logic [11:0] T_ADR_LO21           = 12'd274;
  localparam logic [11:0] T_ADR_PREL_PG_HI21   = 12'd275;
  localparam logic [11:0] T_ADD_ABS_LO12_NC    = 12'd277;
  localparam logic [11:0] T_JUMP26             = 12'd282;
  localparam logic [11:0] T_CALL26             = 12'd283;
  localparam logic [11:0] T_LDST64_ABS_LO12_NC = 12'd286;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISALIGN = 2'd1;
  localparam logic [1:0] ST_UNKNOWN  = 2'd2;

  // Internal patch kinds after decode
  localparam logic [2:0] K_PASS  = 3'd0;
  localparam logic [2:0] K_ABS64 = 3'd1;
  localparam logic [2:0] K_PREL  = 3'd2;
  localparam logic [2:0] K_LO19  = 3'd3;
  localparam logic [2:0] K_HI21  = 3'd4;
  localparam logic [2:0] K_ABS12 = 3'd5;
  localparam logic [2:0] K_JUMP  = 3'd6;
  localparam logic [2:0] K_LDST  = 3'd7;

  // Control carried from operand select to the adder stage
  typedef struct packed {
    logic       swap64;
    logic       swap32;
    logic       half;
    logic [1:0] status;
  } add_ctrl_t;

  function automatic logic [31:0] swap32(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  function automatic logic [63:0] swap64(input logic [63:0] x);
    return {swap32(x[31:0]), swap32(x[63:32])};
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/aarch64_reloc_patch.sv */
// ----------------------------------------------------------------------------
// aarch64_reloc_patch
// Applies one AArch64 ELF relocation to a 64-bit word per transfer.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  s_*     | in        | tdata: old_word[63:0], symbol_value[127:64],
//          |           |        patch_address[191:128]; tuser: action[11:0]
//  m_*     | out       | tdata: new_word[63:0]; tuser: status[1:0]
//  cfg_*   | in        | cfg_wdata: elf_big_endian
//
// Three register stages: decode and subtract, operand select, add and swap.
// One transfer per cycle while m_tready is high, through s1, s2 and s3.
// rst clears all stage valid bits and elf_big_endian.
// Each stage holds while the one after it is full and stalled, so a stall on
// m_tready reaches s_tready only when all three stages are occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module aarch64_reloc_patch
  import arp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  // config
  input  wire logic         cfg_we,
  input  wire logic         cfg_wdata,
  // input stream
  input  wire logic         s_tvalid,
  output      logic         s_tready,
  input  wire logic [191:0] s_tdata,   // old_word, symbol_value, patch_address
  input  wire logic [11:0]  s_tuser,   // action
  // output stream
  output      logic         m_tvalid,
  input  wire logic         m_tready,
  output      logic [63:0]  m_tdata,   // new_word
  output      logic [1:0]   m_tuser    // status
);

  logic elf_big_endian;

  // stage valids and advance enables
  logic s1_valid, s2_valid, s3_valid;
  logic s1_ready, s2_ready, s3_ready;

  assign s3_ready = !s3_valid || m_tready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign s_tready = s1_ready;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      elf_big_endian <= 1'b0;
    end else if (cfg_we) begin
      elf_big_endian <= cfg_wdata;
    end
  end

  // ---------------- stage 1: decode, subtract ----------------
  logic [63:0] in_word, in_sym, in_addr;
  logic [2:0]  dec_kind;
  logic [1:0]  dec_status;

  assign in_word = s_tdata[63:0];
  assign in_sym  = s_tdata[127:64];
  assign in_addr = s_tdata[191:128];

  always_comb begin
    dec_kind   = K_PASS;
    dec_status = ST_OK;
    case (s_tuser)
      T_ABS64:            dec_kind = K_ABS64;
      T_PREL32:           dec_kind = K_PREL;
      T_LD_PREL_LO19:     dec_kind = K_LO19;
      T_ADR_LO21: begin
        if (in_sym[1:0] != 2'b00) dec_status = ST_MISALIGN;
        else                      dec_kind   = K_LO19;
      end
      T_ADR_PREL_PG_HI21: dec_kind = K_HI21;
      T_ADD_ABS_LO12_NC:  dec_kind = K_ABS12;
      T_JUMP26,
      T_CALL26:           dec_kind = K_JUMP;
      T_LDST64_ABS_LO12_NC: begin
        if (in_sym[2:0] != 3'b000) dec_status = ST_MISALIGN;
        else                       dec_kind   = K_LDST;
      end
      default:            dec_status = ST_UNKNOWN;
    endcase
  end

  logic [2:0]  s1_kind;
  logic [1:0]  s1_status;
  logic [63:0] s1_word, s1_sym;
  logic [31:0] s1_delta;
  logic [20:0] s1_page;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s_tvalid) begin
      s1_kind   <= dec_kind;
      s1_status <= dec_status;
      s1_word   <= in_word;
      s1_sym    <= in_sym;
      // only the low bits of each difference reach the patched field
      s1_delta  <= in_sym[31:0] - in_addr[31:0];
      s1_page   <= in_sym[32:12] - in_addr[32:12];
    end
  end

  // ---------------- stage 2: operand select ----------------
  logic [63:0] sel_a, sel_b;
  add_ctrl_t   sel_ctrl;

  always_comb begin
    sel_a           = s1_word;
    sel_b           = 64'd0;
    sel_ctrl.swap64 = 1'b0;
    sel_ctrl.swap32 = 1'b0;
    sel_ctrl.half   = 1'b1;
    sel_ctrl.status = s1_status;
    case (s1_kind)
      K_ABS64: begin
        sel_a           = elf_big_endian ? swap64(s1_word) : s1_word;
        sel_b           = s1_sym;
        sel_ctrl.swap64 = elf_big_endian;
        sel_ctrl.half   = 1'b0;
      end
      K_PREL: begin
        sel_a           = {s1_word[63:32],
                           elf_big_endian ? swap32(s1_word[31:0]) : s1_word[31:0]};
        sel_b           = {32'd0, s1_delta};
        sel_ctrl.swap32 = elf_big_endian;
      end
      K_LO19:  sel_b = {32'd0, 8'd0, s1_delta[20:2], 5'd0};
      K_HI21:  sel_b = {32'd0, 1'b0, s1_page[1:0], 5'd0, s1_page[20:2], 5'd0};
      K_ABS12: sel_b = {32'd0, 10'd0, s1_sym[11:0], 10'd0};
      K_JUMP:  sel_b = {32'd0, 6'd0, s1_delta[27:2]};
      K_LDST:  sel_b = {32'd0, 13'd0, s1_sym[11:3], 10'd0};
      default: sel_ctrl.half = 1'b0;   // pass-through: word + 0
    endcase
  end

  logic [63:0] s2_a, s2_b;
  add_ctrl_t   s2_ctrl;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_a    <= sel_a;
      s2_b    <= sel_b;
      s2_ctrl <= sel_ctrl;
    end
  end

  // ---------------- stage 3: add, swap back ----------------
  logic [63:0] sum, res_word;

  assign sum = s2_a + s2_b;

  always_comb begin
    if (s2_ctrl.half) begin
      res_word = {s2_a[63:32], s2_ctrl.swap32 ? swap32(sum[31:0]) : sum[31:0]};
    end else begin
      res_word = s2_ctrl.swap64 ? swap64(sum) : sum;
    end
  end

  logic [63:0] s3_word;
  logic [1:0]  s3_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid) begin
      s3_word   <= res_word;
      s3_status <= s2_ctrl.status;
    end
  end

  assign m_tvalid = s3_valid;
  assign m_tdata  = s3_word;
  assign m_tuser  = s3_status;

endmodule

`default_nettype wire

/* hw/rtl/arp_checker.sv */
// ----------------------------------------------------------------------------
// arp_checker
// Port-level checks on the relocation patcher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "aarch64_reloc_patch_defines.svh"

module arp_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_tvalid,
  input wire logic         s_tready,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [63:0]  m_tdata,
  input wire logic [1:0]   m_tuser
);

  // nothing comes out straight after reset
  `ARP_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid, "output valid after reset")

  // a stalled result holds
  `ARP_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled output changed")

  // input backpressure only when the output is full and stalled
  `ARP_ASSERT(a_bp_source, !s_tready |-> m_tvalid && !m_tready, "input stalled with room in pipe")

  // a transfer through a flowing pipe reaches the output after the s1, s2 and s3 registers
  `ARP_ASSERT(a_latency, s_tvalid && s_tready ##1 m_tready ##1 m_tready |=> m_tvalid, "transfer lost in flowing pipe")

endmodule

bind aarch64_reloc_patch arp_checker u_arp_checker (.*);

`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relocation patcher testbench
// Streams relocations through aarch64_reloc_patch with random gaps on both
// sides. A scoreboard predicts each patched word and status and checks the
// output transfers in order, under both ELF byte orders.
// ----------------------------------------------------------------------------

import arp_pkg::*;

typedef struct packed {
  logic [63:0] word;
  logic [1:0]  status;
} patched_word_t;

// Predicts the patched word for each accepted relocation and checks results
class reloc_scoreboard;
  bit            big_endian;
  patched_word_t pending_patches[$];
  int            errors;

  function logic [31:0] flip32(logic [31:0] x);
    logic [31:0] r;
    for (int b = 0; b < 4; b++) r[8*b +: 8] = x[8*(3-b) +: 8];
    return r;
  endfunction

  function logic [63:0] flip64(logic [63:0] x);
    logic [63:0] r;
    for (int b = 0; b < 8; b++) r[8*b +: 8] = x[8*(7-b) +: 8];
    return r;
  endfunction

  function patched_word_t apply_reloc(logic [11:0] act, logic [63:0] w,
                                      logic [63:0] s, logic [63:0] p);
    patched_word_t res;
    logic [63:0]   delta;
    logic [63:0]   page;
    logic [63:0]   shifted;
    logic [31:0]   lo;
    logic [31:0]   add;
    bit            low_half;
    delta    = s - p;
    lo       = w[31:0];
    add      = '0;
    low_half = 1'b1;
    res.word   = w;
    res.status = ST_OK;
    case (act)
      T_ABS64: begin
        low_half = 1'b0;
        res.word = big_endian ? flip64(flip64(w) + s) : w + s;
      end
      T_PREL32: begin
        low_half = 1'b0;
        lo = big_endian ? flip32(flip32(lo) + delta[31:0]) : lo + delta[31:0];
        res.word = {w[63:32], lo};
      end
      // the ADR low-21 type shares the LO19 field but checks word alignment
      T_ADR_LO21, T_LD_PREL_LO19: begin
        if (act == T_ADR_LO21 && s[1:0] != 2'b00) begin
          res.status = ST_MISALIGN;
          low_half   = 1'b0;
        end else begin
          shifted = delta << 3;
          add     = shifted[31:0] & 32'h00ff_ffe0;
        end
      end
      T_ADR_PREL_PG_HI21: begin
        page = ({s[63:12], 12'h000} - {p[63:12], 12'h000}) >> 12;
        add  = {1'b0, page[1:0], 29'b0} + {8'b0, page[20:2], 5'b0};
      end
      T_ADD_ABS_LO12_NC: add = {10'b0, s[11:0], 10'b0};
      T_JUMP26, T_CALL26: add = {6'b0, delta[27:2]};
      T_LDST64_ABS_LO12_NC: begin
        if (s[2:0] != 3'b000) begin
          res.status = ST_MISALIGN;
          low_half   = 1'b0;
        end else begin
          add = {13'b0, s[11:3], 10'b0};
        end
      end
      default: begin
        res.status = ST_UNKNOWN;
        low_half   = 1'b0;
      end
    endcase
    if (low_half) res.word = {w[63:32], lo + add};
    return res;
  endfunction

  function void note_reloc(logic [11:0] act, logic [63:0] w,
                           logic [63:0] s, logic [63:0] p);
    pending_patches.push_back(apply_reloc(act, w, s, p));
  endfunction

  function void check_patch(logic [63:0] word, logic [1:0] status);
    patched_word_t exp_patch;
    if (pending_patches.size() == 0) begin
      $display("%0t: unexpected output transfer, word %h status %0d",
               $time, word, status);
      errors++;
      return;
    end
    exp_patch = pending_patches.pop_front();
    if (word !== exp_patch.word) begin
      $display("%0t: new_word expected %h actual %h", $time, exp_patch.word, word);
      errors++;
    end
    if (status !== exp_patch.status) begin
      $display("%0t: status expected %0d actual %0d", $time, exp_patch.status,
               status);
      errors++;
    end
  endfunction
endclass

module testbench;

  localparam int QUIET_LIMIT = 1000;

  logic         clk       = 1'b0;
  logic         rst       = 1'b1;
  logic         cfg_we    = 1'b0;
  logic         cfg_wdata = 1'b0;
  logic         s_tvalid  = 1'b0;
  logic         s_tready;
  logic [191:0] s_tdata   = '0;
  logic [11:0]  s_tuser   = '0;
  logic         m_tvalid;
  logic         m_tready  = 1'b0;
  logic [63:0]  m_tdata;
  logic [1:0]   m_tuser;

  reloc_scoreboard sb = new();
  bit              gaps_on = 1'b1;
  int              quiet_cycles = 0;

  logic [11:0] known_types [9] = '{T_ABS64, T_PREL32, T_LD_PREL_LO19,
                                   T_ADR_LO21, T_ADR_PREL_PG_HI21,
                                   T_ADD_ABS_LO12_NC, T_JUMP26, T_CALL26,
                                   T_LDST64_ABS_LO12_NC};

  aarch64_reloc_patch dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),   // old_word, symbol_value, patch_address
    .s_tuser   (s_tuser),   // action
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),   // new_word
    .m_tuser   (m_tuser)    // status
  );

  always #10 clk = ~clk;

  // Output side: random stall bursts while gaps are enabled
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  // Output monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_patch(m_tdata, m_tuser);
  end

  // Watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One relocation on the input stream, with an optional leading gap
  task automatic send_reloc(input logic [11:0] act, input logic [63:0] w,
                            input logic [63:0] s, input logic [63:0] p);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {p, s, w};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_reloc(act, w, s, p);
  endtask

  // Stop sending and wait for every outstanding result, plus pipeline slack
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending_patches.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_byte_order(input bit be);
    cfg_we    <= 1'b1;
    cfg_wdata <= be;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.big_endian = be;
  endtask

  function automatic logic [63:0] rand64();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_random();
    logic [11:0] act;
    logic [63:0] w;
    logic [63:0] s;
    logic [63:0] p;
    if ($urandom_range(0, 99) < 15) act = 12'($urandom_range(0, 4095));
    else act = known_types[$urandom_range(0, 8)];
    w = rand64();
    s = rand64();
    p = rand64();
    // Keep PC-relative distances near branch range some of the time
    if ($urandom_range(0, 1) == 0) p = s - 64'($urandom_range(0, 1 << 22));
    // Aligned values are rare by chance, so force them half the time
    if ((act == T_ADR_LO21 || act == T_LDST64_ABS_LO12_NC) &&
        $urandom_range(0, 1) == 0) s[2:0] = 3'b000;
    send_reloc(act, w, s, p);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed relocations, little-endian data
    set_byte_order(1'b0);
    send_reloc(T_ABS64, '0, '1, '0);
    send_reloc(T_ABS64, '1, 64'd1, '1);
    send_reloc(T_PREL32, 64'hffff_ffff_0000_0000, '0, '1);
    send_reloc(T_LD_PREL_LO19, '0, '1, '0);
    send_reloc(T_ADR_LO21, '1, 64'h1000, 64'h20);
    send_reloc(T_ADR_LO21, 64'h1234, 64'h1002, 64'h0);
    send_reloc(T_ADR_LO21, 64'h1234, 64'h1001, 64'h0);
    send_reloc(T_ADR_PREL_PG_HI21, 64'h9000_0000, '1, '0);
    send_reloc(T_ADR_PREL_PG_HI21, '0, '0, '1);
    send_reloc(T_ADD_ABS_LO12_NC, '0, '1, '0);
    send_reloc(T_JUMP26, 64'h1400_0000, '0, 64'd4);
    send_reloc(T_CALL26, '1, '1, '0);
    send_reloc(T_LDST64_ABS_LO12_NC, '0, 64'hff8, '0);
    send_reloc(T_LDST64_ABS_LO12_NC, 64'h55, 64'h4, '0);
    send_reloc(12'd0, 64'hdead_beef_0bad_f00d, '1, '1);
    send_reloc(12'd4095, '1, '0, '0);
    send_reloc(12'd258, 64'h0123_4567_89ab_cdef, 64'h10, 64'h8);
    drain();

    // Directed relocations, big-endian data
    set_byte_order(1'b1);
    send_reloc(T_ABS64, 64'h0102_0304_0506_0708, 64'd1, '0);
    send_reloc(T_ABS64, '1, '1, '0);
    send_reloc(T_PREL32, 64'h1122_3344_0000_00ff, 64'h100, '0);
    send_reloc(T_PREL32, '1, '0, '1);
    send_reloc(T_CALL26, 64'h9400_0000, 64'h1000, '0);
    drain();

    // Random phases, alternating byte order; the last one runs without gaps
    for (int ph = 0; ph < 4; ph++) begin
      set_byte_order(ph[0]);
      gaps_on = (ph != 3);
      for (int n = 0; n < 282; n++) begin
        // Hold the sender once until the pipeline has emptied
        if (ph == 1 && n == 141) drain();
        send_random();
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/arp_pkg.sv
hw/rtl/aarch64_reloc_patch.sv
hw/rtl/arp_checker.sv
dv/testbench.sv
